/* src/lps3_pkg.sv */
package lps3_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int DEPTH_BITS_DEF = 16;

  localparam int FRAME_BITS = 13;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [FRAME_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [FRAME_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_width;
    logic [FRAME_BITS-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic line_active;
    logic emit;
  } walk_sts_t;

endpackage

/* src/lps3_if.sv */
interface lps3_in_if #(
  parameter int COORD_BITS = lps3_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = lps3_pkg::DEPTH_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [DEPTH_BITS-1:0] start_z;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic signed [DEPTH_BITS-1:0] end_z;

  modport source (
    output valid, func, start_x, start_y, start_z, end_x, end_y, end_z,
    input  ready
  );
  modport sink (
    input  valid, func, start_x, start_y, start_z, end_x, end_y, end_z,
    output ready
  );
endinterface

interface lps3_out_if #(
  parameter int COORD_BITS = lps3_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = lps3_pkg::DEPTH_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [DEPTH_BITS-1:0] point_z;
  logic                         visible;
  logic                         last;

  modport source (
    output valid, point_x, point_y, point_z, visible, last,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, point_z, visible, last,
    output ready
  );
endinterface

/* src/lps3_cfg.sv */
module lps3_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lps3_pkg::APB_AW-1:0]   paddr,
  input  logic [lps3_pkg::APB_DW-1:0]   pwdata,
  output logic [lps3_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output lps3_pkg::cfg_t                cfg_o
);

  logic [lps3_pkg::FRAME_BITS-1:0] frame_width_q, frame_width_d;
  logic [lps3_pkg::FRAME_BITS-1:0] frame_height_q, frame_height_d;
  logic                            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    frame_width_d  = frame_width_q;
    frame_height_d = frame_height_q;
    prdata         = '0;
    case (paddr[2])
      lps3_pkg::REG_FRAME_WIDTH: begin
        prdata = lps3_pkg::APB_DW'(frame_width_q);
        if (wr_en) begin
          frame_width_d = pwdata[lps3_pkg::FRAME_BITS-1:0];
        end
      end
      lps3_pkg::REG_FRAME_HEIGHT: begin
        prdata = lps3_pkg::APB_DW'(frame_height_q);
        if (wr_en) begin
          frame_height_d = pwdata[lps3_pkg::FRAME_BITS-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= lps3_pkg::FRAME_WIDTH_RST;
      frame_height_q <= lps3_pkg::FRAME_HEIGHT_RST;
    end else begin
      frame_width_q  <= frame_width_d;
      frame_height_q <= frame_height_d;
    end
  end

  assign cfg_o.frame_width  = frame_width_q;
  assign cfg_o.frame_height = frame_height_q;

endmodule

/* src/lps3_walk.sv */
module lps3_walk #(
  parameter int COORD_BITS = lps3_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = lps3_pkg::DEPTH_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic                         func_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [DEPTH_BITS-1:0] start_z_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic signed [DEPTH_BITS-1:0] end_z_i,
  input  lps3_pkg::cfg_t               cfg_i,
  output lps3_pkg::walk_sts_t          sts_o,
  output logic signed [COORD_BITS-1:0] point_x_o,
  output logic signed [COORD_BITS-1:0] point_y_o,
  output logic signed [DEPTH_BITS-1:0] point_z_o,
  output logic                         visible_o,
  output logic                         last_o
);

  localparam int W  = (COORD_BITS > DEPTH_BITS) ? COORD_BITS : DEPTH_BITS;
  localparam int DW = W + 1;
  localparam int AW = W;
  localparam int TW = W + 1;
  localparam int EW = W + 3;
  localparam int VW = (COORD_BITS > lps3_pkg::FRAME_BITS) ? COORD_BITS
                                                           : lps3_pkg::FRAME_BITS;

  logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d;
  logic signed [COORD_BITS-1:0] cur_y_q, cur_y_d;
  logic signed [DEPTH_BITS-1:0] cur_z_q, cur_z_d;
  logic signed [EW-1:0]         err_a_q, err_a_d;
  logic signed [EW-1:0]         err_b_q, err_b_d;
  logic [TW-1:0]                twice_dx_q, twice_dx_d;
  logic [TW-1:0]                twice_dy_q, twice_dy_d;
  logic [TW-1:0]                twice_dz_q, twice_dz_d;
  logic [2:0]                   signs_q, signs_d;
  lps3_pkg::axis_e              major_q, major_d;
  logic [AW-1:0]                steps_q, steps_d;
  logic                         active_q, active_d;

  // line setup
  logic signed [DW-1:0] dx, dy, dz;
  logic [AW-1:0]        ax, ay, az;
  logic [TW-1:0]        tx, ty, tz;

  // stepping
  logic [TW-1:0]        t_maj, t_a, t_b;
  logic                 pos_a, pos_b;
  logic signed [EW-1:0] err_a_nx, err_b_nx;
  logic                 mv_x, mv_y, mv_z;
  logic                 last;

  always_comb begin
    dx = DW'(end_x_i) - DW'(start_x_i);
    dy = DW'(end_y_i) - DW'(start_y_i);
    dz = DW'(end_z_i) - DW'(start_z_i);
    ax = dx[DW-1] ? AW'(-dx) : AW'(dx);
    ay = dy[DW-1] ? AW'(-dy) : AW'(dy);
    az = dz[DW-1] ? AW'(-dz) : AW'(dz);
    tx = {ax, 1'b0};
    ty = {ay, 1'b0};
    tz = {az, 1'b0};
  end

  always_comb begin
    case (major_q)
      lps3_pkg::AXIS_X: begin
        t_maj = twice_dx_q;
        t_a   = twice_dy_q;
        t_b   = twice_dz_q;
      end
      lps3_pkg::AXIS_Y: begin
        t_maj = twice_dy_q;
        t_a   = twice_dx_q;
        t_b   = twice_dz_q;
      end
      lps3_pkg::AXIS_Z: begin
        t_maj = twice_dz_q;
        t_a   = twice_dy_q;
        t_b   = twice_dx_q;
      end
      default: begin
        t_maj = twice_dx_q;
        t_a   = twice_dy_q;
        t_b   = twice_dz_q;
      end
    endcase
    pos_a    = !err_a_q[EW-1] && (err_a_q != '0);
    pos_b    = !err_b_q[EW-1] && (err_b_q != '0);
    err_a_nx = err_a_q - (pos_a ? $signed(EW'(t_maj)) : '0) + $signed(EW'(t_a));
    err_b_nx = err_b_q - (pos_b ? $signed(EW'(t_maj)) : '0) + $signed(EW'(t_b));
    mv_x = (major_q == lps3_pkg::AXIS_X) ||
           ((major_q == lps3_pkg::AXIS_Y) && pos_a) ||
           ((major_q == lps3_pkg::AXIS_Z) && pos_b);
    mv_y = (major_q == lps3_pkg::AXIS_Y) ||
           ((major_q == lps3_pkg::AXIS_X) && pos_a) ||
           ((major_q == lps3_pkg::AXIS_Z) && pos_a);
    mv_z = (major_q == lps3_pkg::AXIS_Z) ||
           ((major_q == lps3_pkg::AXIS_X) && pos_b) ||
           ((major_q == lps3_pkg::AXIS_Y) && pos_b);
    last = (steps_q == '0);
  end

  always_comb begin
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    cur_z_d    = cur_z_q;
    err_a_d    = err_a_q;
    err_b_d    = err_b_q;
    twice_dx_d = twice_dx_q;
    twice_dy_d = twice_dy_q;
    twice_dz_d = twice_dz_q;
    signs_d    = signs_q;
    major_d    = major_q;
    steps_d    = steps_q;
    active_d   = active_q;
    if (acc_i && (func_i == lps3_pkg::FUNC_LOAD)) begin
      cur_x_d    = start_x_i;
      cur_y_d    = start_y_i;
      cur_z_d    = start_z_i;
      twice_dx_d = tx;
      twice_dy_d = ty;
      twice_dz_d = tz;
      signs_d    = {dz[DW-1], dy[DW-1], dx[DW-1]};
      active_d   = 1'b1;
      if ((ax >= ay) && (ax >= az)) begin
        major_d = lps3_pkg::AXIS_X;
        err_a_d = $signed(EW'(ty)) - $signed(EW'(ax));
        err_b_d = $signed(EW'(tz)) - $signed(EW'(ax));
        steps_d = ax;
      end else if (ay >= az) begin
        major_d = lps3_pkg::AXIS_Y;
        err_a_d = $signed(EW'(tx)) - $signed(EW'(ay));
        err_b_d = $signed(EW'(tz)) - $signed(EW'(ay));
        steps_d = ay;
      end else begin
        major_d = lps3_pkg::AXIS_Z;
        err_a_d = $signed(EW'(ty)) - $signed(EW'(az));
        err_b_d = $signed(EW'(tx)) - $signed(EW'(az));
        steps_d = az;
      end
    end else if (acc_i && active_q) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        err_a_d = err_a_nx;
        err_b_d = err_b_nx;
        steps_d = steps_q - AW'(1);
        if (mv_x) begin
          cur_x_d = cur_x_q + {{(COORD_BITS-1){signs_q[0]}}, 1'b1};
        end
        if (mv_y) begin
          cur_y_d = cur_y_q + {{(COORD_BITS-1){signs_q[1]}}, 1'b1};
        end
        if (mv_z) begin
          cur_z_d = cur_z_q + {{(DEPTH_BITS-1){signs_q[2]}}, 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      cur_z_q    <= '0;
      err_a_q    <= '0;
      err_b_q    <= '0;
      twice_dx_q <= '0;
      twice_dy_q <= '0;
      twice_dz_q <= '0;
      signs_q    <= '0;
      major_q    <= lps3_pkg::AXIS_X;
      steps_q    <= '0;
      active_q   <= 1'b0;
    end else begin
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      cur_z_q    <= cur_z_d;
      err_a_q    <= err_a_d;
      err_b_q    <= err_b_d;
      twice_dx_q <= twice_dx_d;
      twice_dy_q <= twice_dy_d;
      twice_dz_q <= twice_dz_d;
      signs_q    <= signs_d;
      major_q    <= major_d;
      steps_q    <= steps_d;
      active_q   <= active_d;
    end
  end

  assign sts_o.line_active = active_q;
  assign sts_o.emit        = active_q && (func_i == lps3_pkg::FUNC_STEP);

  assign point_x_o = cur_x_q;
  assign point_y_o = cur_y_q;
  assign point_z_o = cur_z_q;
  assign last_o    = last;
  assign visible_o = !cur_x_q[COORD_BITS-1] && !cur_y_q[COORD_BITS-1] &&
                     (VW'($unsigned(cur_x_q)) < VW'(cfg_i.frame_width)) &&
                     (VW'($unsigned(cur_y_q)) < VW'(cfg_i.frame_height));

endmodule

/* src/line_point_stepper_3d_top.sv */
// 3d line walker: a load word sets up a line, each step word gives one point
// a step word's point is captured in the output register when the word is accepted
// throughput: one word per cycle while the output register is not held by a stalled sink
// load words and step words with no line give no result
// reset: no line active, frame 640 x 480, output register empty
module line_point_stepper_3d_top #(
  parameter int COORD_BITS = lps3_pkg::COORD_BITS_DEF,
  parameter int DEPTH_BITS = lps3_pkg::DEPTH_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lps3_in_if.sink                     in_i,
  lps3_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lps3_pkg::APB_AW-1:0] paddr,
  input  logic [lps3_pkg::APB_DW-1:0] pwdata,
  output logic [lps3_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  lps3_pkg::cfg_t      cfg;
  lps3_pkg::walk_sts_t sts;

  logic                         acc;
  logic                         out_valid_q, out_valid_d;
  logic signed [COORD_BITS-1:0] pt_x, pt_y;
  logic signed [DEPTH_BITS-1:0] pt_z;
  logic                         pt_vis, pt_last;
  logic signed [COORD_BITS-1:0] point_x_q;
  logic signed [COORD_BITS-1:0] point_y_q;
  logic signed [DEPTH_BITS-1:0] point_z_q;
  logic                         visible_q;
  logic                         last_q;

  lps3_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lps3_walk #(
    .COORD_BITS (COORD_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_walk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .func_i    (in_i.func),
    .start_x_i (in_i.start_x),
    .start_y_i (in_i.start_y),
    .start_z_i (in_i.start_z),
    .end_x_i   (in_i.end_x),
    .end_y_i   (in_i.end_y),
    .end_z_i   (in_i.end_z),
    .cfg_i     (cfg),
    .sts_o     (sts),
    .point_x_o (pt_x),
    .point_y_o (pt_y),
    .point_z_o (pt_z),
    .visible_o (pt_vis),
    .last_o    (pt_last)
  );

  // output register frees up in the cycle its word is taken
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (acc && sts.emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && sts.emit) begin
      point_x_q <= pt_x;
      point_y_q <= pt_y;
      point_z_q <= pt_z;
      visible_q <= pt_vis;
      last_q    <= pt_last;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.point_x = point_x_q;
  assign out_o.point_y = point_y_q;
  assign out_o.point_z = point_z_q;
  assign out_o.visible = visible_q;
  assign out_o.last    = last_q;

  a_load_starts_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (in_i.func == lps3_pkg::FUNC_LOAD)) |=> sts.line_active)
    else $error("load word did not start a line");

  a_last_ends_line : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && sts.emit && pt_last) |=> !sts.line_active)
    else $error("line still active after its last point");

  a_emit_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && sts.emit) |=> out_valid_q)
    else $error("emitted point not held in output register");

  a_no_emit_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.emit |-> sts.line_active)
    else $error("point emitted with no line active");

endmodule
